### rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on aclk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define NPC_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("npc assertion failed");

`define NPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("npc assertion failed");

`else

`define NPC_ASSERT(label, cond)
`define NPC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/npc_pkg.sv
package npc_pkg;

    localparam int PALETTE_DEPTH = 16;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int CHAN_W        = 8;
    localparam int DIST_W        = 10;
    localparam int COUNT_W       = 5;

    localparam logic [DIST_W-1:0] DIST_START = DIST_W'(768);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MAP  = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

    // search beat travelling down the cell row
    typedef struct packed {
        logic              valid;
        color_t            pixel;
        logic [IDX_W-1:0]  best_idx;
        color_t            best_color;
        logic [DIST_W-1:0] best_dist;
    } token_t;

    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

### rtl/npc_cell.sv
module npc_cell
    import npc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             wr_en,
    input  color_t           wr_color,
    input  logic [IDX_W-1:0] cell_index,
    input  logic             active,
    input  token_t           tok_in,
    output token_t           tok_out
);

    color_t            entry_reg;
    token_t            tok_reg;
    token_t            tok_next;
    logic [DIST_W-1:0] cell_dist;

    assign cell_dist = DIST_W'(absdiff(tok_in.pixel.red,   entry_reg.red))
                     + DIST_W'(absdiff(tok_in.pixel.green, entry_reg.green))
                     + DIST_W'(absdiff(tok_in.pixel.blue,  entry_reg.blue));

    always_comb begin
        tok_next = tok_in;
        // strict compare keeps the lowest index on ties
        if (active && (cell_dist < tok_in.best_dist)) begin
            tok_next.best_idx   = cell_index;
            tok_next.best_color = entry_reg;
            tok_next.best_dist  = cell_dist;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg <= wr_color;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else if (advance) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/nearest_palette_color.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    action, entry_index, red, green, blue
// m_        out  m_valid/m_ready    best_index, out_red/green/blue, distance
// cfg_      in   cfg_we             cfg_wdata (palette_count)
// A load beat writes its entry directly. A map beat walks the row of
// PALETTE_DEPTH cells, one cell per cycle while the row advances, then
// lands in the output register; every cell is walked whatever the
// count. One map is in flight at a time; s_ready is low meanwhile and
// rises with the capture, after which the next beat can be taken.
// A result held in the output register stalls the row only when the next
// result reaches its end. Reset clears the count to 1; palette is not reset.
`include "assert_macros.svh"

module nearest_palette_color
    import npc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [IDX_W-1:0]   s_entry_index,
    input  logic [CHAN_W-1:0]  s_red,
    input  logic [CHAN_W-1:0]  s_green,
    input  logic [CHAN_W-1:0]  s_blue,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [IDX_W-1:0]   m_best_index,
    output logic [CHAN_W-1:0]  m_out_red,
    output logic [CHAN_W-1:0]  m_out_green,
    output logic [CHAN_W-1:0]  m_out_blue,
    output logic [DIST_W-1:0]  m_distance
);

    logic [COUNT_W-1:0]     palette_count_reg;
    logic                   busy_reg;
    logic                   out_valid_reg;
    token_t                 out_tok_reg;

    token_t                 chain [PALETTE_DEPTH+1];
    logic [PALETTE_DEPTH-1:0] tok_valid;
    color_t                 in_color;
    logic                   in_accept;
    logic                   load_beat;
    logic                   map_beat;
    logic                   capture;
    logic                   advance;

    assign s_ready   = !busy_reg;
    assign in_accept = s_valid && s_ready;
    assign load_beat = in_accept && (s_action == ACT_LOAD);
    assign map_beat  = in_accept && (s_action == ACT_MAP);
    assign in_color  = '{red: s_red, green: s_green, blue: s_blue};

    assign capture = chain[PALETTE_DEPTH].valid && (!out_valid_reg || m_ready);
    assign advance = !chain[PALETTE_DEPTH].valid || capture;

    always_comb begin
        chain[0]            = '0;
        chain[0].valid      = map_beat;
        chain[0].pixel      = in_color;
        chain[0].best_dist  = DIST_START;
    end

    for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
        logic wr_en;
        logic active;

        assign wr_en  = load_beat && (s_entry_index == IDX_W'(i));
        // entry 0 is always searched; counts beyond the depth saturate
        assign active = (i == 0) || (i < int'(palette_count_reg));
        assign tok_valid[i] = chain[i+1].valid;

        npc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .wr_en      (wr_en),
            .wr_color   (in_color),
            .cell_index (IDX_W'(i)),
            .active     (active),
            .tok_in     (chain[i]),
            .tok_out    (chain[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_count_reg <= COUNT_W'(1);
            busy_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                palette_count_reg <= cfg_wdata;
            end
            if (map_beat) begin
                busy_reg <= 1'b1;
            end else if (capture) begin
                busy_reg <= 1'b0;
            end
            if (capture) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            out_tok_reg <= chain[PALETTE_DEPTH];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_best_index = out_tok_reg.best_idx;
    assign m_out_red    = out_tok_reg.best_color.red;
    assign m_out_green  = out_tok_reg.best_color.green;
    assign m_out_blue   = out_tok_reg.best_color.blue;
    assign m_distance   = out_tok_reg.best_dist;

    `NPC_ASSERT(a_one_search, $countones(tok_valid) <= 1)
    `NPC_ASSERT(a_busy_tracks_row, busy_reg == (|tok_valid))
    `NPC_ASSERT_NEXT(a_dist_range, capture, m_valid && (m_distance <= DIST_W'(765)))

endmodule

### tb/sv/nearest_palette_color_tb.sv
module nearest_palette_color_tb
    import npc_pkg::*;
();

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = PALETTE_DEPTH + 4;
    localparam int RAND_PER_PHASE = 88;
    localparam int LONG_HOLD      = 400;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        color_t            color;
        logic [DIST_W-1:0] dist_val;
    } match_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               action;
        logic [IDX_W-1:0]   idx;
        color_t             pixel;
        logic               typed;
        match_t             res;
    } dir_row_t;

    // count, action, index, pixel, typed, expected match
    localparam dir_row_t DIR_TAB [25] = '{
        '{5'd1,  ACT_LOAD, 4'd0,  24'h000000, 1'b0, '0},
        '{5'd1,  ACT_MAP,  4'd0,  24'hFFFFFF, 1'b1, '{4'd0, 24'h000000, 10'd765}},
        '{5'd1,  ACT_MAP,  4'd15, 24'h000000, 1'b1, '{4'd0, 24'h000000, 10'd0}},
        '{5'd1,  ACT_LOAD, 4'd1,  24'hFFFFFF, 1'b0, '0},
        '{5'd1,  ACT_MAP,  4'd0,  24'hFFFFFF, 1'b1, '{4'd0, 24'h000000, 10'd765}},
        '{5'd2,  ACT_MAP,  4'd0,  24'hFFFFFF, 1'b1, '{4'd1, 24'hFFFFFF, 10'd0}},
        '{5'd2,  ACT_LOAD, 4'd2,  24'hFFFFFF, 1'b0, '0},
        '{5'd3,  ACT_MAP,  4'd0,  24'hFAFAFA, 1'b1, '{4'd1, 24'hFFFFFF, 10'd15}},
        '{5'd0,  ACT_MAP,  4'd0,  24'hFFFFFF, 1'b1, '{4'd0, 24'h000000, 10'd765}},
        '{5'd0,  ACT_LOAD, 4'd3,  24'h807F01, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd4,  24'h123456, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd5,  24'hFE0180, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd6,  24'h00FF00, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd7,  24'hFF0000, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd8,  24'h0000FF, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd9,  24'h55AA55, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd10, 24'hAA55AA, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd11, 24'h7F807F, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd12, 24'h40C020, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd13, 24'hC86432, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd14, 24'h010203, 1'b0, '0},
        '{5'd0,  ACT_LOAD, 4'd15, 24'hFFFFFE, 1'b0, '0},
        '{5'd31, ACT_MAP,  4'd0,  24'hFFFFFE, 1'b1, '{4'd15, 24'hFFFFFE, 10'd0}},
        '{5'd16, ACT_MAP,  4'd0,  24'hFFFFFF, 1'b1, '{4'd1, 24'hFFFFFF, 10'd0}},
        '{5'd16, ACT_MAP,  4'd9,  24'h6B2A90, 1'b0, '0}
    };

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata     = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic               s_action      = ACT_LOAD;
    logic [IDX_W-1:0]   s_entry_index = '0;
    logic [CHAN_W-1:0]  s_red         = '0;
    logic [CHAN_W-1:0]  s_green       = '0;
    logic [CHAN_W-1:0]  s_blue        = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [IDX_W-1:0]   m_best_index;
    logic [CHAN_W-1:0]  m_out_red;
    logic [CHAN_W-1:0]  m_out_green;
    logic [CHAN_W-1:0]  m_out_blue;
    logic [DIST_W-1:0]  m_distance;

    color_t             pal_mirror [PALETTE_DEPTH];
    logic [COUNT_W-1:0] search_count   = 5'd1;
    match_t             pending_matches [$];
    int                 miss_count     = 0;
    int                 cycle_count    = 0;
    int                 send_idle_pct  = 0;
    int                 sink_stall_pct = 0;
    int                 hold_req       = 0;

    nearest_palette_color dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_entry_index (s_entry_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_best_index  (m_best_index),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_distance    (m_distance)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("nearest_palette_color_tb: errors");
            $finish;
        end
    end

    function automatic int chan_gap(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
        return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // first entry at least distance among the searched ones
    function automatic match_t nearest_entry(input color_t px);
        match_t best;
        int     n;
        int     d;
        if (search_count == 0)
            n = 1;
        else if (search_count > PALETTE_DEPTH)
            n = PALETTE_DEPTH;
        else
            n = int'(search_count);
        best.idx      = '0;
        best.dist_val = DIST_START;
        for (int i = 0; i < n; i++) begin
            d = chan_gap(px.red, pal_mirror[i].red) + chan_gap(px.green, pal_mirror[i].green)
                + chan_gap(px.blue, pal_mirror[i].blue);
            if (d < int'(best.dist_val)) begin
                best.dist_val = DIST_W'(d);
                best.idx      = IDX_W'(i);
            end
        end
        best.color = pal_mirror[best.idx];
        return best;
    endfunction

    task automatic log_miss(input string what, input match_t want, input match_t got);
        miss_count++;
        if (miss_count <= 10)
            $display("%s: expected idx %0d rgb %06h dist %0d, got idx %0d rgb %06h dist %0d",
                     what, want.idx, want.color, want.dist_val, got.idx, got.color,
                     got.dist_val);
    endtask

    task automatic put_beat(input logic action, input logic [IDX_W-1:0] idx, input color_t px,
                            input logic typed, input match_t typed_res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= action;
        s_entry_index <= idx;
        s_red         <= px.red;
        s_green       <= px.green;
        s_blue        <= px.blue;
        do @(posedge aclk); while (!s_ready);
        if (action == ACT_LOAD)
            pal_mirror[idx] = px;
        else
            pending_matches.push_back(typed ? typed_res : nearest_entry(px));
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_matches.size() != 0);
    endtask

    // block must be idle: drain results, then let a trailing load settle
    task automatic load_count(input logic [COUNT_W-1:0] cnt);
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cnt;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        search_count  = cnt;
    endtask

    task automatic random_beat();
        color_t           px;
        logic [IDX_W-1:0] idx;
        logic             act;
        idx = IDX_W'($urandom_range(PALETTE_DEPTH - 1));
        act = ($urandom_range(99) < 70) ? ACT_MAP : ACT_LOAD;
        px  = 24'($urandom());
        if ($urandom_range(99) < 30) begin
            // close to or equal to a stored color: ties and small distances
            px     = pal_mirror[$urandom_range(PALETTE_DEPTH - 1)];
            px.red = px.red ^ 8'($urandom_range(3));
        end
        put_beat(act, idx, px, 1'b0, '0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [COUNT_W-1:0] cnt, input bit long_hold,
                             input bit mid_pause);
        load_count(cnt);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        if (long_hold)
            hold_req = LONG_HOLD;
        for (int n = 0; n < RAND_PER_PHASE; n++) begin
            if (mid_pause && n == RAND_PER_PHASE / 2)
                wait_results();
            random_beat();
        end
    endtask

    // result side: ready pattern and checking
    initial begin
        match_t want;
        match_t got;
        int     hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.idx      = m_best_index;
                got.color    = {m_out_red, m_out_green, m_out_blue};
                got.dist_val = m_distance;
                if (pending_matches.size() == 0) begin
                    log_miss("unexpected beat", '0, got);
                end else begin
                    want = pending_matches.pop_front();
                    if (got.idx !== want.idx || got.color.red !== want.color.red
                        || got.color.green !== want.color.green
                        || got.color.blue !== want.color.blue
                        || got.dist_val !== want.dist_val)
                        log_miss("mismatch", want, got);
                end
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        dir_row_t row;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // every entry is loaded before any search reaches it
        foreach (DIR_TAB[i]) begin
            row = DIR_TAB[i];
            if (row.count != search_count)
                load_count(row.count);
            put_beat(row.action, row.idx, row.pixel, row.typed, row.res);
        end
        run_phase(0, 0, 5'd16, 1'b0, 1'b0);
        run_phase(65, 0, 5'd1, 1'b0, 1'b0);
        run_phase(0, 65, 5'd31, 1'b0, 1'b0);
        run_phase(26, 26, 5'd0, 1'b0, 1'b0);
        run_phase(0, 0, 5'd17, 1'b1, 1'b0);
        run_phase(26, 26, COUNT_W'($urandom_range(31)), 1'b0, 1'b1);
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (miss_count == 0 && pending_matches.size() == 0) begin
            $display("nearest_palette_color_tb: clean");
        end else begin
            $display("nearest_palette_color_tb: errors");
        end
        $finish;
    end

endmodule
